[sv/rokg_pkg.sv]
// Package for the random operation/key generator.
// Shared constants and types; used by the front end, back end, top level and testbench.
`default_nettype none
package rokg_pkg;

   localparam int unsigned STATE_W     = 31;
   localparam int unsigned DRAW_W      = 15;
   localparam int unsigned KEY_W       = 14;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned DIV_CNT_W   = $clog2(DRAW_W);

   localparam logic [STATE_W-1:0] LCG_MUL     = 31'd1103515245;
   localparam logic [STATE_W-1:0] LCG_ADD     = 31'd12345;
   localparam logic [STATE_W-1:0] STATE_RESET = 31'd1;
   localparam logic [KEY_W-1:0]   RANGE_MIN   = 14'd10;
   localparam logic [KEY_W-1:0]   RANGE_RESET = 14'd100;
   localparam logic [16:0]        DRAW_SPAN   = 17'd32768;

   localparam logic REG_SEED  = 1'b0;
   localparam logic REG_RANGE = 1'b1;

   typedef struct packed {
      logic               seed_wr;
      logic [STATE_W-1:0] seed;
      logic [KEY_W-1:0]   key_range;
   } cfg_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_MUL   = 6'b000010,
      ST_ADD   = 6'b000100,
      ST_DIV   = 6'b001000,
      ST_CHECK = 6'b010000,
      ST_OUT   = 6'b100000
   } back_state_type;

endpackage
`default_nettype wire

[sv/rokg_front.sv]
// Front end: accepts request transactions, drops idle ones, queues the rest.
// Depends on rokg_pkg.
`default_nettype none
module rokg_front (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   input  wire logic req_bit,
   output logic      tok_valid,
   input  wire logic tok_pop
);

   logic [rokg_pkg::QCNT_W-1:0] cnt_ff, cnt_in;
   logic                        push;

   assign req_ready = (cnt_ff < rokg_pkg::QCNT_W'(rokg_pkg::QUEUE_DEPTH));
   assign push      = req_valid & req_ready & req_bit;
   assign tok_valid = (cnt_ff != '0);

   always_comb begin
      cnt_in = cnt_ff;
      case ({push, tok_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

[sv/rokg_back.sv]
// Back end: LCG stepping, rejection test via serial remainder, result register.
// Depends on rokg_pkg.
`default_nettype none
module rokg_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire rokg_pkg::cfg_type             cfg,
   input  wire logic                          tok_valid,
   output logic                               tok_pop,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic                               out_op,
   output logic [rokg_pkg::KEY_W-1:0]         out_key
);

   rokg_pkg::back_state_type          st_ff, st_in;
   logic [rokg_pkg::STATE_W-1:0]      state_ff, state_in;
   logic [rokg_pkg::STATE_W-1:0]      prod_ff, prod_in;
   logic                              first_ff, first_in;
   logic                              op_ff, op_in;
   logic [rokg_pkg::DRAW_W-1:0]       draw_ff, draw_in;
   logic [rokg_pkg::DRAW_W-1:0]       shf_ff, shf_in;
   logic [rokg_pkg::KEY_W-1:0]        rem_ff, rem_in;
   logic [rokg_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                              ov_ff, ov_in;
   logic                              oop_ff, oop_in;
   logic [rokg_pkg::KEY_W-1:0]        okey_ff, okey_in;
   logic [rokg_pkg::STATE_W-1:0]      next_state;
   logic [rokg_pkg::KEY_W:0]          trial;
   logic [16:0]                       span_end;
   logic                              reject;

   assign next_state = prod_ff + rokg_pkg::LCG_ADD;
   assign trial      = {rem_ff, shf_ff[rokg_pkg::DRAW_W-1]};
   assign span_end   = {2'b00, draw_ff} - {3'b000, rem_ff} + {3'b000, cfg.key_range};
   assign reject     = (span_end > rokg_pkg::DRAW_SPAN);

   assign tok_pop   = (st_ff == rokg_pkg::ST_IDLE) & tok_valid;
   assign out_valid = ov_ff;
   assign out_op    = oop_ff;
   assign out_key   = okey_ff;

   always_comb begin
      st_in    = st_ff;
      state_in = state_ff;
      prod_in  = prod_ff;
      first_in = first_ff;
      op_in    = op_ff;
      draw_in  = draw_ff;
      shf_in   = shf_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      ov_in    = ov_ff & ~out_ready;
      oop_in   = oop_ff;
      okey_in  = okey_ff;
      case (st_ff)
         rokg_pkg::ST_IDLE: begin
            if (tok_valid) begin
               first_in = 1'b1;
               st_in    = rokg_pkg::ST_MUL;
            end
         end
         rokg_pkg::ST_MUL: begin
            prod_in = state_ff * rokg_pkg::LCG_MUL;
            st_in   = rokg_pkg::ST_ADD;
         end
         rokg_pkg::ST_ADD: begin
            state_in = next_state;
            if (first_ff) begin
               op_in    = next_state[16];
               first_in = 1'b0;
               st_in    = rokg_pkg::ST_MUL;
            end else begin
               draw_in = next_state[30:16];
               shf_in  = next_state[30:16];
               rem_in  = '0;
               cnt_in  = '0;
               st_in   = rokg_pkg::ST_DIV;
            end
         end
         rokg_pkg::ST_DIV: begin
            if (trial >= {1'b0, cfg.key_range}) begin
               rem_in = rokg_pkg::KEY_W'(trial - {1'b0, cfg.key_range});
            end else begin
               rem_in = trial[rokg_pkg::KEY_W-1:0];
            end
            shf_in = {shf_ff[rokg_pkg::DRAW_W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == rokg_pkg::DIV_CNT_W'(rokg_pkg::DRAW_W - 1)) begin
               st_in = rokg_pkg::ST_CHECK;
            end
         end
         rokg_pkg::ST_CHECK: begin
            st_in = reject ? rokg_pkg::ST_MUL : rokg_pkg::ST_OUT;
         end
         rokg_pkg::ST_OUT: begin
            if (!ov_ff || out_ready) begin
               ov_in   = 1'b1;
               oop_in  = op_ff;
               okey_in = rem_ff + 1'b1;
               st_in   = rokg_pkg::ST_IDLE;
            end
         end
         default: begin
            st_in = rokg_pkg::ST_IDLE;
         end
      endcase
      if (cfg.seed_wr) begin
         state_in = cfg.seed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= rokg_pkg::ST_IDLE;
         state_ff <= rokg_pkg::STATE_RESET;
         ov_ff    <= 1'b0;
         first_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         st_ff    <= st_in;
         state_ff <= state_in;
         ov_ff    <= ov_in;
         first_ff <= first_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      op_ff   <= op_in;
      draw_ff <= draw_in;
      shf_ff  <= shf_in;
      rem_ff  <= rem_in;
      oop_ff  <= oop_in;
      okey_ff <= okey_in;
   end

endmodule
`default_nettype wire

[sv/random_op_key_generator_top.sv]
// Top level of the random operation/key generator: CSR port, front and back ends.
// Depends on rokg_pkg, rokg_front, rokg_back.
//
// Each request transaction with request=1 yields one result: an operation bit and a
// key uniform on 1..key_range, drawn from the 31-bit ANSI C style LCG. Each item steps
// the generator once for the operation bit and once per key draw, each step a multiply
// and then an add; a bit-serial remainder unit reduces each 15-bit draw, and a rejected
// draw is replaced by a new one. Requests with request=0 are accepted and give no result.
// Up to 4 requests queue ahead of the back end, and a finished result waits in its
// output register without holding up the queue.
`default_nettype none
module random_op_key_generator_top #(
   parameter int unsigned RANGE_MAX = 10000
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [0] request
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,    // [13:0] key_value
   output logic [0:0]       rsp_tuser,    // [0] op_kind
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam logic [15:0] RangeMax16 = 16'(RANGE_MAX);
   localparam logic [rokg_pkg::KEY_W-1:0] RangeResetClamped =
      (RANGE_MAX < 100) ? rokg_pkg::KEY_W'(RANGE_MAX) : rokg_pkg::RANGE_RESET;

   logic [31:0]                 seed_ff, seed_in;
   logic [rokg_pkg::KEY_W-1:0]  range_ff, range_in;
   logic [rokg_pkg::KEY_W-1:0]  wr_range;
   logic                        wr_en;
   rokg_pkg::cfg_type           cfg;
   logic                        tok_valid;
   logic                        tok_pop;
   logic                        out_op;
   logic [rokg_pkg::KEY_W-1:0]  out_key;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      wr_range = csr_pwdata[rokg_pkg::KEY_W-1:0];
      if (wr_range < rokg_pkg::RANGE_MIN) begin
         wr_range = rokg_pkg::RANGE_MIN;
      end else if ({2'b00, wr_range} > RangeMax16) begin
         wr_range = RangeMax16[rokg_pkg::KEY_W-1:0];
      end
   end

   always_comb begin
      seed_in  = seed_ff;
      range_in = range_ff;
      if (wr_en) begin
         case (csr_paddr[2])
            rokg_pkg::REG_SEED:  seed_in  = csr_pwdata;
            rokg_pkg::REG_RANGE: range_in = wr_range;
            default:             seed_in  = seed_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         rokg_pkg::REG_SEED:  csr_prdata = seed_ff;
         rokg_pkg::REG_RANGE: csr_prdata = {18'd0, range_ff};
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= 32'd1;
         range_ff <= RangeResetClamped;
      end else begin
         seed_ff  <= seed_in;
         range_ff <= range_in;
      end
   end

   assign cfg.seed_wr   = wr_en & (csr_paddr[2] == rokg_pkg::REG_SEED);
   assign cfg.seed      = csr_pwdata[rokg_pkg::STATE_W-1:0];
   assign cfg.key_range = range_ff;

   rokg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_bit   (req_tdata[0]),
      .tok_valid (tok_valid),
      .tok_pop   (tok_pop)
   );

   rokg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .tok_valid (tok_valid),
      .tok_pop   (tok_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_op    (out_op),
      .out_key   (out_key)
   );

   assign rsp_tdata = {2'b00, out_key};
   assign rsp_tuser = out_op;

endmodule
`default_nettype wire

[sv/rokg_checker.sv]
// Port-level checker for the random operation/key generator, with its bind.
// Depends on random_op_key_generator_top.
`default_nettype none
module rokg_checker #(
   parameter int unsigned RANGE_MAX = 10000
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic [0:0]  rsp_tuser
);

   localparam logic [15:0] RangeMax16 = 16'(RANGE_MAX);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp transaction changed while stalled");

   a_key_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[13:0] != 14'd0)
      else $error("key below 1");

   a_key_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({2'b00, rsp_tdata[13:0]} <= RangeMax16) && (rsp_tdata[15:14] == 2'b00))
      else $error("key above range limit");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind random_op_key_generator_top rokg_checker #(.RANGE_MAX(RANGE_MAX)) u_rokg_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

[tb/random_op_key_generator_top_tb.sv]
// Testbench for random_op_key_generator_top: request ticks in, operation and key out.
// Predicts every result with its own LCG and rejection-sampling model; both stream
// sides stall at random save in one burst. Depends on rokg_pkg and the top-level RTL.
`timescale 1ns / 1ps

module random_op_key_generator_top_tb;

   localparam int unsigned RANGE_MAX    = 10000;
   localparam int unsigned SETTLE_TICKS = 64;
   localparam int unsigned STALL_LIMIT  = 4000;
   localparam int unsigned REPORT_MAX   = 10;

   typedef enum bit {OP_GET = 1'b0, OP_INVERT = 1'b1} op_type;

   typedef struct {
      op_type                     op;
      logic [rokg_pkg::KEY_W-1:0] key;
   } key_item_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;     // [0] request
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;     // [13:0] key_value
   logic [0:0]  rsp_tuser;     // [0] op_kind
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   logic [rokg_pkg::STATE_W-1:0] model_state;
   int unsigned                  model_range;
   key_item_type                 expected_keys[$];

   bit          stall_on = 1'b1;
   int unsigned error_count;
   int unsigned key_requests;
   int unsigned idle_requests;
   int unsigned invert_count;
   int unsigned checked_count;
   int unsigned settings_count;
   int unsigned quiet_cycles;

   random_op_key_generator_top #(
      .RANGE_MAX(RANGE_MAX)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int unsigned clamp_range(input logic [31:0] value);
      int unsigned r;
      r = value[rokg_pkg::KEY_W-1:0];
      if (r < rokg_pkg::RANGE_MIN)
         return rokg_pkg::RANGE_MIN;
      if (r > RANGE_MAX)
         return RANGE_MAX;
      return r;
   endfunction

   // state wraps at 31 bits; a draw is bits 30..16
   function automatic logic [rokg_pkg::DRAW_W-1:0] next_draw();
      model_state = model_state * rokg_pkg::LCG_MUL + rokg_pkg::LCG_ADD;
      return model_state[rokg_pkg::STATE_W-1:16];
   endfunction

   function automatic key_item_type predict_op_key();
      key_item_type                item;
      logic [rokg_pkg::DRAW_W-1:0] d;
      int unsigned                 bound;
      d       = next_draw();
      item.op = d[0] ? OP_INVERT : OP_GET;
      bound   = (32768 / model_range) * model_range;
      do
         d = next_draw();
      while (d >= bound);
      item.key = rokg_pkg::KEY_W'(d % model_range + 1);
      return item;
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic send_request(input bit want_key);
      key_item_type item;
      while (stall_on && $urandom_range(99) < 38) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, want_key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (want_key) begin
         item = predict_op_key();
         expected_keys.push_back(item);
         key_requests++;
         if (item.op == OP_INVERT)
            invert_count++;
      end else begin
         idle_requests++;
      end
   endtask

   // lower valid, let all results come back, then give idle requests time to drain
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_keys.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_register(input logic reg_index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (reg_index == rokg_pkg::REG_SEED)
         model_state = value[rokg_pkg::STATE_W-1:0];
      else
         model_range = clamp_range(value);
   endtask

   task automatic apply_settings(input bit load_seed, input logic [31:0] seed,
                                 input logic [31:0] range_value);
      settle();
      if (load_seed)
         write_register(rokg_pkg::REG_SEED, seed);
      write_register(rokg_pkg::REG_RANGE, range_value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      settings_count++;
   endtask

   // ---------------------------------------------------------------- checking

   task automatic note_mismatch(input string msg);
      error_count++;
      if (error_count <= REPORT_MAX)
         $display("[%0t] MISMATCH: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin : check_results
      key_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_keys.size() == 0) begin
            note_mismatch($sformatf("unexpected result op %0d key %0d",
                                    rsp_tuser[0], rsp_tdata[rokg_pkg::KEY_W-1:0]));
         end else begin
            want = expected_keys.pop_front();
            checked_count++;
            if (rsp_tuser[0] !== want.op)
               note_mismatch($sformatf("op_kind expected %0d got %0d",
                                       want.op, rsp_tuser[0]));
            if (rsp_tdata[rokg_pkg::KEY_W-1:0] !== want.key)
               note_mismatch($sformatf("key_value expected %0d got %0d",
                                       want.key, rsp_tdata[rokg_pkg::KEY_W-1:0]));
         end
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= !stall_on || ($urandom_range(99) >= 38);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                  quiet_cycles, expected_keys.size());
         $display("random_op_key_generator_top_tb failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_reset_defaults();
      send_request(1'b1);
      send_request(1'b1);
      send_request(1'b0);
      send_request(1'b1);
   endtask

   task automatic test_idle_requests();
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b1);
   endtask

   task automatic test_range_limits();
      logic [31:0] ranges[6] = '{32'd0, 32'd9, 32'd10, 32'd10000, 32'd10001, 32'hFFFF_FFFF};
      foreach (ranges[i]) begin
         apply_settings(1'b0, '0, ranges[i]);
         send_request(1'b1);
         send_request(1'b1);
      end
   endtask

   // 8193 gives a rejection rate near one in four
   task automatic test_seed_extremes();
      apply_settings(1'b1, 32'h0000_0000, 32'd8193);
      send_request(1'b1);
      send_request(1'b1);
      apply_settings(1'b1, 32'hFFFF_FFFF, 32'd8193);
      send_request(1'b1);
      send_request(1'b1);
      apply_settings(1'b1, 32'h8000_0000, 32'd10);
      send_request(1'b1);
   endtask

   task automatic test_random_traffic(input int unsigned n_keys);
      logic [31:0] seed;
      logic [31:0] range_value;
      int unsigned pick;
      int unsigned target;
      pick = $urandom_range(99);
      if (pick < 6)
         seed = 32'h0000_0000;
      else if (pick < 12)
         seed = 32'hFFFF_FFFF;
      else
         seed = $urandom;
      pick = $urandom_range(99);
      if (pick < 5)
         range_value = $urandom_range(9);
      else if (pick < 10)
         range_value = $urandom_range(16383, 10001);
      else if (pick < 15)
         range_value = $urandom;
      else if (pick < 20)
         range_value = 32'd10;
      else if (pick < 25)
         range_value = 32'd10000;
      else if (pick < 30)
         range_value = 32'd8193;
      else
         range_value = $urandom_range(10000, 10);
      apply_settings($urandom_range(3) != 0, seed, range_value);
      target = key_requests + n_keys;
      while (key_requests < target)
         send_request($urandom_range(99) >= 12);
   endtask

   task automatic test_unstalled_burst(input int unsigned n_keys);
      stall_on = 1'b0;
      test_random_traffic(n_keys);
      settle();
      stall_on = 1'b1;
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      model_state = rokg_pkg::STATE_RESET;
      model_range = rokg_pkg::RANGE_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_idle_requests();
      test_range_limits();
      test_seed_extremes();
      repeat (3) test_random_traffic(170);
      test_unstalled_burst(150);
      repeat (4) test_random_traffic(170);

      settle();
      if (expected_keys.size() != 0) begin
         error_count += expected_keys.size();
         $display("%0d expected results never arrived", expected_keys.size());
      end
      $display("covered %0d key requests (%0d invert) and %0d idle requests",
               key_requests, invert_count, idle_requests);
      $display("checked %0d results over %0d register settings", checked_count,
               settings_count);
      if (error_count == 0)
         $display("random_op_key_generator_top_tb passed");
      else
         $display("random_op_key_generator_top_tb failed");
      $finish;
   end

endmodule
